@@ hw/rtl/kmrd_pkg.sv @@
`timescale 1ns / 1ps

package kmrd_pkg;

	// Fixed field widths of the scan and result channels, and of the history, shift and length fields.
	localparam int PIN_W     = 15;
	localparam int ELAPSED_W = 16;
	localparam int ROW_IDX_W = 3;
	localparam int HIST_W    = 8;
	localparam int SHIFT_W   = 4;
	localparam int LEN_W     = 4;

	// Largest shift taken per row-zero pass, the legal debounce length range and the reset debounce length.
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;
	localparam logic [LEN_W-1:0]   LEN_MIN   = 4'd1;
	localparam logic [LEN_W-1:0]   LEN_MAX   = 4'd8;
	localparam logic [LEN_W-1:0]   LEN_RESET = 4'd5;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_DEBOUNCE_LEN = 1'b0
	} cfg_reg_t;

	// Per-scan controls handed to the row update logic.
	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic [HIST_W-1:0]  mask;
	} upd_ctrl_t;

	// True when the value is a nonzero run of ones starting at bit zero.
	function automatic logic low_run(logic [HIST_W-1:0] v);
		logic [HIST_W:0] p;
		p = {1'b0, v} + {{HIST_W{1'b0}}, 1'b1};
		return (v != '0) && (({1'b0, v} & p) == '0);
	endfunction

endpackage

@@ hw/rtl/kmrd_scan_if.sv @@
`timescale 1ns / 1ps

interface kmrd_scan_if;
	import kmrd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PIN_W-1:0]     col_pins_n;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, col_pins_n, elapsed_ms, input ready);
	modport sink (input valid, col_pins_n, elapsed_ms, output ready);
endinterface

@@ hw/rtl/kmrd_result_if.sv @@
`timescale 1ns / 1ps

interface kmrd_result_if;
	import kmrd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ROW_IDX_W-1:0] row_index;
	logic                 scanned;
	logic [PIN_W-1:0]     row_keys;
	logic [PIN_W-1:0]     bounce_cols;

	modport source (output valid, row_index, scanned, row_keys, bounce_cols, input ready);
	modport sink (input valid, row_index, scanned, row_keys, bounce_cols, output ready);
endinterface

@@ hw/rtl/kmrd_ram.sv @@
`timescale 1ns / 1ps

module kmrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/kmrd_row_update.sv @@
`timescale 1ns / 1ps

module kmrd_row_update
	import kmrd_pkg::*;
#(
	parameter int COLS = 15
) (
	input  upd_ctrl_t              ctrl,
	input  logic [PIN_W-1:0]       pins_n,
	input  logic [COLS*HIST_W-1:0] old_hist,
	input  logic [COLS-1:0]        old_state,
	output logic [COLS*HIST_W-1:0] new_hist,
	output logic [COLS-1:0]        new_state,
	output logic [COLS-1:0]        bounce
);

	logic [HIST_W:0] fill;

	// Ones shifted in for a closed key, one per elapsed millisecond.
	assign fill = (({{HIST_W{1'b0}}, 1'b1}) << ctrl.shift) - {{HIST_W{1'b0}}, 1'b1};

	for (genvar i = 0; i < COLS; i++) begin : g_col
		logic                closed;
		logic [2*HIST_W-1:0] shifted;
		logic [HIST_W-1:0]   h;
		logic [HIST_W-1:0]   v;
		logic                st;

		// Columns past the pin field read as open.
		if (i < PIN_W) begin : g_pin
			assign closed = ~pins_n[i];
		end else begin : g_nopin
			assign closed = 1'b0;
		end

		assign shifted = {{HIST_W{1'b0}}, old_hist[i*HIST_W +: HIST_W]} << ctrl.shift;
		assign h = shifted[HIST_W-1:0] | (closed ? fill[HIST_W-1:0] : '0);
		assign v = h & ctrl.mask;

		// Classify the newest samples: released, pressed, held or bounce.
		always_comb begin
			st = old_state[i];
			bounce[i] = 1'b0;
			if (ctrl.shift != '0) begin
				if (v == '0) begin
					st = 1'b0;
				end else if (low_run(v)) begin
					st = 1'b1;
				end else if (!low_run(~v & ctrl.mask)) begin
					bounce[i] = 1'b1;
				end
			end
		end

		assign new_hist[i*HIST_W +: HIST_W] = (ctrl.shift != '0) ? h : old_hist[i*HIST_W +: HIST_W];

		// Key state is kept only within the pin field.
		if (i < PIN_W) begin : g_st
			assign new_state[i] = st;
		end else begin : g_nost
			assign new_state[i] = 1'b0;
		end
	end

endmodule

@@ hw/rtl/key_matrix_row_debouncer.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// scan     in   valid/ready    col_pins_n[14:0], elapsed_ms[15:0]
// result   out  valid/ready    row_index[2:0], scanned, row_keys[14:0], bounce_cols[14:0]
// apb      in   psel/penable   debounce_len at byte address 0
//
// One request per cycle unless the result stalls; stage one feeds the result register.
// Histories and key states of a row sit in one word of a RAM with a registered read;
// the row is read on acceptance and written back when the result is registered.
// A write to the row just read is forwarded. Reset clears the per-row valid bits,
// so no clearing pass is needed. A stalled result holds the update stage.

module key_matrix_row_debouncer
	import kmrd_pkg::*;
#(
	parameter int ROWS = 5,
	parameter int COLS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	kmrd_scan_if.sink          scan,
	kmrd_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WW = COLS * HIST_W + COLS;
	localparam logic [RW:0] ROWS_L = (RW + 1)'(ROWS);

	logic [LEN_W-1:0]   len_q;
	logic [RW-1:0]      row_q;
	logic [SHIFT_W-1:0] latched_q;
	logic [ROWS-1:0]    row_vld_q;

	logic               vld_s1;
	logic [RW-1:0]      row_s1;
	logic [SHIFT_W-1:0] shift_s1;
	logic [PIN_W-1:0]   pins_s1;
	logic               fwd_s1;
	logic               rowvld_s1;
	logic [WW-1:0]      fwd_word_q;

	logic               accept;
	logic               adv;
	logic [SHIFT_W-1:0] shift_in;
	logic [RW:0]        row_inc;
	logic [WW-1:0]      ram_rdata;
	logic [WW-1:0]      old_word;
	logic [WW-1:0]      new_word;
	logic [COLS-1:0]    bounce;
	logic [LEN_W-1:0]   len_clamped;
	upd_ctrl_t          ctrl;
	logic [PIN_W-1:0]   keys_w;
	logic [PIN_W-1:0]   bounce_w;
	logic [RW+ROW_IDX_W-1:0] row_ext;

	// Configuration port: single register, always ready.
	assign pready = 1'b1;
	assign prdata = {{(32 - LEN_W){1'b0}}, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (psel && penable && pwrite && (cfg_reg_t'(paddr[2]) == REG_DEBOUNCE_LEN)) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	// Handshake control for the update stage and the result register.
	assign adv    = vld_s1 && (!result.valid || result.ready);
	assign scan.ready = !vld_s1 || adv;
	assign accept = scan.valid && scan.ready;

	// Shift count: relatched at row zero, saturated to the maximum.
	always_comb begin
		if (row_q == '0) begin
			shift_in = (scan.elapsed_ms > ELAPSED_W'(MAX_SHIFT)) ? MAX_SHIFT
				: scan.elapsed_ms[SHIFT_W-1:0];
		end else begin
			shift_in = latched_q;
		end
	end

	assign row_inc = {1'b0, row_q} + {{RW{1'b0}}, 1'b1};

	// Row counter, latched shift and per-row valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			latched_q <= '0;
			row_vld_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (accept) begin
				row_q     <= (row_inc >= ROWS_L) ? '0 : row_inc[RW-1:0];
				latched_q <= shift_in;
			end
			if (adv) begin
				row_vld_q[row_s1] <= 1'b1;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Stage one payload, including the forwarding decision for the row read.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1    <= row_q;
			shift_s1  <= shift_in;
			pins_s1   <= scan.col_pins_n;
			fwd_s1    <= adv && (row_s1 == row_q);
			rowvld_s1 <= row_vld_q[row_q];
		end
		if (adv) begin
			fwd_word_q <= new_word;
		end
	end

	kmrd_ram #(
		.WIDTH (WW),
		.DEPTH (ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (row_s1),
		.wdata (new_word),
		.re    (accept),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	// Pick the freshest copy of the row; a never-written row reads as zero.
	always_comb begin
		if (fwd_s1) begin
			old_word = fwd_word_q;
		end else if (rowvld_s1) begin
			old_word = ram_rdata;
		end else begin
			old_word = '0;
		end
	end

	// Debounce length clamped to the legal range, then turned into a mask.
	always_comb begin
		if (len_q < LEN_MIN) begin
			len_clamped = LEN_MIN;
		end else if (len_q > LEN_MAX) begin
			len_clamped = LEN_MAX;
		end else begin
			len_clamped = len_q;
		end
		ctrl.shift = shift_s1;
		ctrl.mask  = HIST_W'(({{HIST_W{1'b0}}, 1'b1} << len_clamped) - {{HIST_W{1'b0}}, 1'b1});
	end

	kmrd_row_update #(
		.COLS (COLS)
	) u_row_update (
		.ctrl      (ctrl),
		.pins_n    (pins_s1),
		.old_hist  (old_word[COLS*HIST_W-1:0]),
		.old_state (old_word[WW-1:COLS*HIST_W]),
		.new_hist  (new_word[COLS*HIST_W-1:0]),
		.new_state (new_word[WW-1:COLS*HIST_W]),
		.bounce    (bounce)
	);

	// Fit the column masks to the result field width.
	for (genvar j = 0; j < PIN_W; j++) begin : g_out
		if (j < COLS) begin : g_has
			assign keys_w[j]   = new_word[COLS*HIST_W + j];
			assign bounce_w[j] = bounce[j];
		end else begin : g_none
			assign keys_w[j]   = 1'b0;
			assign bounce_w[j] = 1'b0;
		end
	end

	assign row_ext = {{ROW_IDX_W{1'b0}}, row_s1};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (adv) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.row_index   <= row_ext[ROW_IDX_W-1:0];
			result.scanned     <= (shift_s1 != '0);
			result.row_keys    <= keys_w;
			result.bounce_cols <= bounce_w;
		end
	end

endmodule
